FILE: rtl/core/mdet_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths and the permutation table of the determinant block.
// No dependencies; every other file but mdet_ram imports this package.
package mdet_pkg;

    localparam int MAX_SIZE = 4;
    localparam int IDX_W    = 2;
    localparam int ADDR_W   = 2 * IDX_W;
    localparam int DEPTH    = MAX_SIZE * MAX_SIZE;
    localparam int ELEM_W   = 8;
    localparam int SIZE_W   = 3;
    localparam int DET_W    = 34;
    localparam int PROD_W   = 32;
    localparam int NUM_PERM = 24;
    localparam int PERM_W   = 5;

    typedef enum logic [2:0] {
        E_IDLE,
        E_PERM,
        E_READ,
        E_MUL,
        E_ACC,
        E_OUT
    } eng_state_t;

    typedef struct packed {
        logic              start;
        logic [SIZE_W-1:0] size;
    } eng_ctrl_t;

    typedef struct packed {
        logic busy;
    } eng_stat_t;

    // Permutations of four columns in lexicographic order.
    // Bit 8: odd permutation; bits [2r+1:2r]: column taken in row r.
    function automatic logic [8:0] perm_entry(input logic [PERM_W-1:0] p);
        logic [8:0] e;
        case (p)
            5'd0:  e = {1'b0, 2'd3, 2'd2, 2'd1, 2'd0};
            5'd1:  e = {1'b1, 2'd2, 2'd3, 2'd1, 2'd0};
            5'd2:  e = {1'b1, 2'd3, 2'd1, 2'd2, 2'd0};
            5'd3:  e = {1'b0, 2'd1, 2'd3, 2'd2, 2'd0};
            5'd4:  e = {1'b0, 2'd2, 2'd1, 2'd3, 2'd0};
            5'd5:  e = {1'b1, 2'd1, 2'd2, 2'd3, 2'd0};
            5'd6:  e = {1'b1, 2'd3, 2'd2, 2'd0, 2'd1};
            5'd7:  e = {1'b0, 2'd2, 2'd3, 2'd0, 2'd1};
            5'd8:  e = {1'b0, 2'd3, 2'd0, 2'd2, 2'd1};
            5'd9:  e = {1'b1, 2'd0, 2'd3, 2'd2, 2'd1};
            5'd10: e = {1'b1, 2'd2, 2'd0, 2'd3, 2'd1};
            5'd11: e = {1'b0, 2'd0, 2'd2, 2'd3, 2'd1};
            5'd12: e = {1'b0, 2'd3, 2'd1, 2'd0, 2'd2};
            5'd13: e = {1'b1, 2'd1, 2'd3, 2'd0, 2'd2};
            5'd14: e = {1'b1, 2'd3, 2'd0, 2'd1, 2'd2};
            5'd15: e = {1'b0, 2'd0, 2'd3, 2'd1, 2'd2};
            5'd16: e = {1'b0, 2'd1, 2'd0, 2'd3, 2'd2};
            5'd17: e = {1'b1, 2'd0, 2'd1, 2'd3, 2'd2};
            5'd18: e = {1'b1, 2'd2, 2'd1, 2'd0, 2'd3};
            5'd19: e = {1'b0, 2'd1, 2'd2, 2'd0, 2'd3};
            5'd20: e = {1'b0, 2'd2, 2'd0, 2'd1, 2'd3};
            5'd21: e = {1'b1, 2'd0, 2'd2, 2'd1, 2'd3};
            5'd22: e = {1'b1, 2'd1, 2'd0, 2'd2, 2'd3};
            5'd23: e = {1'b0, 2'd0, 2'd1, 2'd2, 2'd3};
            default: e = {1'b0, 2'd3, 2'd2, 2'd1, 2'd0};
        endcase
        return e;
    endfunction

endpackage

FILE: rtl/core/matrix_determinant_top.sv
`timescale 1ns / 1ps
// Top level of the matrix determinant block: size register, load counters,
// matrix RAM and determinant engine. Depends on mdet_pkg, mdet_ram, mdet_engine.
//
//  channel  | signals                      | carries
//  ---------+------------------------------+-------------------------------
//  input    | s_tvalid s_tready s_tdata    | one matrix element, row-major
//  output   | m_tvalid m_tready m_tdata    | determinant of the loaded matrix
//  config   | cfg_wr_en cfg_wr_data        | matrix size
//
// Elements load at one per cycle into the matrix RAM while the engine is idle.
// After the last one the engine walks all 24 permutations: a check step per
// permutation plus, for each that fits the size, a RAM read and a multiply per
// row and one accumulate step; after that the result item waits until taken.
// Loading stalls until the result item is taken. Reset clears control state
// only; the RAM holds no defined content until loaded.
module matrix_determinant_top
    import mdet_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,     // [7:0] element
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [39:0]       m_tdata,     // [33:0] det_value, [39:34] zero
    input  logic              cfg_wr_en,
    input  logic [SIZE_W-1:0] cfg_wr_data
);

    logic [SIZE_W-1:0] size_reg, size_next;
    logic [IDX_W-1:0]  row_reg, row_next;
    logic [IDX_W-1:0]  col_reg, col_next;
    logic [IDX_W-1:0]  last_idx;
    logic              in_acc;
    logic              last_elem;
    eng_ctrl_t         ctrl;
    eng_stat_t         stat;
    logic [ADDR_W-1:0] raddr;
    logic [ELEM_W-1:0] rdata;
    logic [DET_W-1:0]  det;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg <= SIZE_W'(MAX_SIZE);
            row_reg  <= '0;
            col_reg  <= '0;
        end else begin
            size_reg <= size_next;
            row_reg  <= row_next;
            col_reg  <= col_next;
        end
    end

    assign s_tready  = !stat.busy;
    assign in_acc    = s_tvalid && s_tready;
    assign last_idx  = IDX_W'(size_reg - SIZE_W'(1));
    assign last_elem = (row_reg == last_idx) && (col_reg == last_idx);

    always_comb begin
        size_next = size_reg;
        row_next  = row_reg;
        col_next  = col_reg;
        if (cfg_wr_en) begin
            // clamp to 1..MAX_SIZE, drop any partial matrix
            if (cfg_wr_data == '0) begin
                size_next = SIZE_W'(1);
            end else if (cfg_wr_data > SIZE_W'(MAX_SIZE)) begin
                size_next = SIZE_W'(MAX_SIZE);
            end else begin
                size_next = cfg_wr_data;
            end
            row_next = '0;
            col_next = '0;
        end else if (in_acc) begin
            if (last_elem) begin
                row_next = '0;
                col_next = '0;
            end else if (col_reg == last_idx) begin
                col_next = '0;
                row_next = row_reg + IDX_W'(1);
            end else begin
                col_next = col_reg + IDX_W'(1);
            end
        end
    end

    // The last write lands as the engine leaves E_IDLE, ahead of its first read in E_READ.
    assign ctrl.start = in_acc && last_elem && !cfg_wr_en;
    assign ctrl.size  = size_reg;

    mdet_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (in_acc),
        .waddr ({row_reg, col_reg}),
        .wdata (s_tdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    mdet_engine u_engine (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (ctrl),
        .stat     (stat),
        .raddr    (raddr),
        .rdata    (rdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .det      (det)
    );

    assign m_tdata = {6'b0, det};

`ifndef SYNTHESIS
    a_no_load_while_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input ready while a result is pending");

    a_start_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.start |=> !s_tready)
        else $error("engine did not take the completed matrix");

    a_cfg_restarts_load: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr_en |=> (row_reg == '0 && col_reg == '0))
        else $error("size write did not restart the load");
`endif

endmodule

FILE: rtl/core/mdet_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mdet_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/core/mdet_engine.sv
`timescale 1ns / 1ps
// Determinant engine: walks all permutations, reads one factor per step
// from the matrix RAM, accumulates signed products. Depends on mdet_pkg.
module mdet_engine
    import mdet_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  eng_ctrl_t         ctrl,
    output eng_stat_t         stat,
    output logic [ADDR_W-1:0] raddr,
    input  logic [ELEM_W-1:0] rdata,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [DET_W-1:0]  det
);

    eng_state_t          state_reg, state_next;
    logic [PERM_W-1:0]   perm_reg, perm_next;
    logic [IDX_W-1:0]    row_reg, row_next;
    logic [SIZE_W-1:0]   size_reg, size_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;
    logic [DET_W-1:0]    acc_reg, acc_next;
    logic [8:0]          pent;
    logic                perm_ok;
    logic [IDX_W-1:0]    last_row;
    logic signed [PROD_W+ELEM_W-1:0] mul_full;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= E_IDLE;
        end else begin
            state_reg <= state_next;
        end
        perm_reg <= perm_next;
        row_reg  <= row_next;
        size_reg <= size_next;
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
    end

    assign pent     = perm_entry(perm_reg);
    assign last_row = IDX_W'(size_reg - SIZE_W'(1));
    assign mul_full = $signed(prod_reg) * $signed(rdata);
    assign raddr    = {row_reg, pent[2*row_reg +: IDX_W]};

    // Rows beyond the matrix in use act as identity rows.
    always_comb begin
        perm_ok = 1'b1;
        for (int r = 0; r < MAX_SIZE; r++) begin
            if (SIZE_W'(r) >= size_reg && pent[2*r +: IDX_W] != IDX_W'(r)) begin
                perm_ok = 1'b0;
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        perm_next  = perm_reg;
        row_next   = row_reg;
        size_next  = size_reg;
        prod_next  = prod_reg;
        acc_next   = acc_reg;
        case (state_reg)
            E_IDLE: begin
                if (ctrl.start) begin
                    size_next  = ctrl.size;
                    perm_next  = '0;
                    row_next   = '0;
                    acc_next   = '0;
                    state_next = E_PERM;
                end
            end
            E_PERM: begin
                row_next = '0;
                if (perm_ok) begin
                    state_next = E_READ;
                end else if (perm_reg == PERM_W'(NUM_PERM - 1)) begin
                    state_next = E_OUT;
                end else begin
                    perm_next = perm_reg + PERM_W'(1);
                end
            end
            E_READ: begin
                state_next = E_MUL;
            end
            E_MUL: begin
                if (row_reg == '0) begin
                    prod_next = PROD_W'($signed(rdata));
                end else begin
                    prod_next = mul_full[PROD_W-1:0];
                end
                if (row_reg == last_row) begin
                    state_next = E_ACC;
                end else begin
                    row_next   = row_reg + IDX_W'(1);
                    state_next = E_READ;
                end
            end
            E_ACC: begin
                if (pent[8]) begin
                    acc_next = acc_reg - DET_W'($signed(prod_reg));
                end else begin
                    acc_next = acc_reg + DET_W'($signed(prod_reg));
                end
                if (perm_reg == PERM_W'(NUM_PERM - 1)) begin
                    state_next = E_OUT;
                end else begin
                    perm_next  = perm_reg + PERM_W'(1);
                    state_next = E_PERM;
                end
            end
            E_OUT: begin
                if (m_tready) begin
                    state_next = E_IDLE;
                end
            end
            default: begin
                state_next = E_IDLE;
            end
        endcase
    end

    assign stat.busy = (state_reg != E_IDLE);
    assign m_tvalid  = (state_reg == E_OUT);
    assign det       = acc_reg;

endmodule

FILE: test/matrix_determinant_checker.sv
`timescale 1ns / 1ps
// Checker for the matrix determinant block: watches the element, result and
// size-write channels, predicts each determinant and compares. Uses mdet_pkg.
module matrix_determinant_checker
    import mdet_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [7:0]        s_tdata,
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [39:0]       m_tdata,
    input  logic              cfg_wr_en,
    input  logic [SIZE_W-1:0] cfg_wr_data,
    output int                fail_count,
    output int                pending_dets,
    output int                dets_seen
);

    logic signed [ELEM_W-1:0] grid [MAX_SIZE][MAX_SIZE];
    logic [SIZE_W-1:0]        size_reg;
    int                       loaded;
    logic [DET_W-1:0]         det_queue [$];

    function automatic int active_size(input logic [SIZE_W-1:0] s);
        if (s == 0) return 1;
        if (s > MAX_SIZE) return MAX_SIZE;
        return int'(s);
    endfunction

    // Cofactor expansion along the top remaining row; used marks taken columns.
    function automatic longint cofactor_det(input int row, input int used, input int n);
        longint sum;
        int     pos;
        sum = 0;
        pos = 0;
        for (int j = 0; j < n; j++) begin
            if (used[j]) continue;
            if (row + 1 >= n) return longint'(grid[row][j]);
            if (pos % 2 == 0)
                sum += longint'(grid[row][j]) * cofactor_det(row + 1, used | (1 << j), n);
            else
                sum -= longint'(grid[row][j]) * cofactor_det(row + 1, used | (1 << j), n);
            pos++;
        end
        return sum;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    initial begin
        fail_count   = 0;
        dets_seen    = 0;
        pending_dets = 0;
    end

    always @(posedge aclk) begin
        int               n;
        longint           d;
        logic [DET_W-1:0] want;
        if (!aresetn) begin
            size_reg <= 3'd4;
            loaded   = 0;
        end else begin
            n = active_size(size_reg);
            if (cfg_wr_en) begin
                size_reg <= cfg_wr_data;
                loaded   = 0;
            end else if (s_tvalid && s_tready) begin
                grid[loaded / n][loaded % n] = s_tdata;
                loaded++;
                if (loaded >= n * n) begin
                    loaded = 0;
                    d = cofactor_det(0, 0, n);
                    det_queue.push_back(d[DET_W-1:0]);
                end
            end
            if (m_tvalid && m_tready) begin
                dets_seen++;
                if (det_queue.size() == 0) begin
                    report_mismatch("unexpected det", longint'(signed'(m_tdata[DET_W-1:0])), 0);
                end else begin
                    want = det_queue.pop_front();
                    if (m_tdata[DET_W-1:0] !== want)
                        report_mismatch("det_value", longint'(signed'(m_tdata[DET_W-1:0])),
                                        longint'(signed'(want)));
                    if (m_tdata[39:34] !== 6'd0)
                        report_mismatch("pad bits", longint'(m_tdata[39:34]), 0);
                end
            end
        end
        pending_dets = det_queue.size();
    end

endmodule

FILE: test/matrix_determinant_top_test.sv
`timescale 1ns / 1ps
// Stimulus and verdict for matrix_determinant_top: directed and random matrices
// over all sizes. Depends on mdet_pkg, the block and matrix_determinant_checker.
module matrix_determinant_top_test;
    import mdet_pkg::*;

    localparam longint CYCLE_LIMIT = 2_000_000;
    localparam int     TAIL_CYCLES = 400;

    logic              aclk;
    logic              aresetn;
    logic              s_tvalid;
    logic              s_tready;
    logic [7:0]        s_tdata;
    logic              m_tvalid;
    logic              m_tready;
    logic [39:0]       m_tdata;
    logic              cfg_wr_en;
    logic [SIZE_W-1:0] cfg_wr_data;
    int                fail_count;
    int                pending_dets;
    int                dets_seen;
    int                elements_sent;
    bit                calm;
    longint            cycles;

    matrix_determinant_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
    );

    matrix_determinant_checker chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .fail_count(fail_count), .pending_dets(pending_dets), .dets_seen(dets_seen)
    );

    initial begin
        aclk = 0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("timeout after %0d cycles", cycles);
                $display("matrix_determinant_top_test NOT OK");
                $finish;
            end
        end
    end

    // Result side: random stall bursts, none in the calm phase.
    initial begin
        int burst;
        m_tready = 0;
        forever begin
            @(posedge aclk);
            if (burst > 0) begin
                burst--;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                burst = $urandom_range(1, 11);
                m_tready <= 0;
            end else begin
                m_tready <= 1;
            end
        end
    end

    task automatic send_element(input logic [7:0] value);
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata  <= value;
        do @(posedge aclk); while (!s_tready);
        elements_sent++;
    endtask

    task automatic hold_idle();
        s_tvalid <= 0;
        @(posedge aclk);
        while (pending_dets != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
    endtask

    // Write the size register while the block is idle.
    task automatic write_size(input logic [SIZE_W-1:0] value);
        hold_idle();
        cfg_wr_en   <= 1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 0;
    endtask

    function automatic logic [7:0] pick_element();
        case ($urandom_range(0, 5))
            0: return 8'h80;
            1: return 8'h7f;
            2: return 8'h00;
            default: return 8'($urandom);
        endcase
    endfunction

    initial begin
        int n;
        s_tvalid = 0;
        s_tdata = 0;
        cfg_wr_en = 0;
        cfg_wr_data = 0;
        aresetn = 0;
        calm = 0;
        elements_sent = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Reset size is 4: extremes of the largest matrix.
        for (int i = 0; i < 16; i++) send_element((i % 5 == 0) ? 8'h80 : 8'h7f);
        write_size(3'd1);
        send_element(8'h80);
        send_element(8'h7f);
        write_size(3'd0);                 // zero acts as one
        send_element(8'hff);
        write_size(3'd7);                 // above maximum saturates to four
        for (int i = 0; i < 5; i++) send_element(8'h55);
        write_size(3'd2);                 // drop the partial matrix
        for (int i = 0; i < 4; i++) send_element(8'h80);

        while (elements_sent < 1750) begin
            n = $urandom_range(0, 7);
            write_size(3'(n));
            n = (n == 0) ? 1 : (n > 4 ? 4 : n);
            if (elements_sent > 1550) calm = 1;
            repeat ($urandom_range(1, 8)) begin
                for (int i = 0; i < n * n; i++) send_element(pick_element());
            end
            // Occasionally abandon a partial matrix at the next size write.
            if ($urandom_range(0, 4) == 0 && n > 1)
                for (int i = 0; i < $urandom_range(1, n * n - 1); i++)
                    send_element(pick_element());
        end
        hold_idle();

        $display("sent %0d elements over sizes 0..7; %0d determinants checked",
                 elements_sent, dets_seen);
        if (fail_count == 0 && pending_dets == 0)
            $display("matrix_determinant_top_test OK");
        else
            $display("matrix_determinant_top_test NOT OK");
        $finish;
    end

endmodule
